@@ rtl/bfla_pkg.sv @@
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared constants, types and helpers for the block free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfla_pkg;

  localparam int TOTAL_BLOCKS           = 1024;
  localparam int BLOCK_BYTES            = 512;
  localparam int MAX_BLOCKS_PER_REQUEST = 10;

  localparam int IDX_W   = $clog2(TOTAL_BLOCKS);         // ring index, block number
  localparam int CNT_W   = $clog2(TOTAL_BLOCKS + 1);     // free, used and fill counts
  localparam int BYTES_W = 16;
  localparam int NEED_W  = $clog2(((1 << BYTES_W) + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);
  localparam int REM_W   = $clog2(MAX_BLOCKS_PER_REQUEST + 1);
  localparam int STAT_W  = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_GRANTED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd3;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;    // capture the accepted request
    logic issue_read;   // start the first ring read at the head
    logic emit_single;  // load the one-result answer (release or refusal)
    logic emit_grant;   // load a granted block, pop and read ahead
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic grant_ok;     // allocate that will be served from the ring
    logic out_free;     // output register can take a result
    logic last_grant;   // one block still to hand out
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    ring_next = (pos == IDX_W'(TOTAL_BLOCKS - 1)) ? '0 : pos + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfla_ram.sv @@
// ----------------------------------------------------------------------------
// bfla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfla_ctrl
// Request sequencer: accept, decide, then emit one or several results.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire bfla_pkg::dp_stat_t   stat,
  output bfla_pkg::ctrl_cmd_t       cmd
);

  import bfla_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SINGLE = 2'd2;
  localparam logic [1:0] S_GRANT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.grant_ok) begin
          cmd.issue_read = 1'b1;
          state_next     = S_GRANT;
        end else begin
          state_next = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_GRANT: begin
        if (stat.out_free) begin
          cmd.emit_grant = 1'b1;
          if (stat.last_grant) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Grant phase is only entered from the decision or continues itself
  a_grant_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT) |-> ($past(state) == S_DECIDE || $past(state) == S_GRANT))
    else $error("grant phase entered without a decision");

endmodule

`default_nettype wire

@@ rtl/bfla_dp.sv @@
// ----------------------------------------------------------------------------
// bfla_dp
// Ring memory, pointers, counters, request decode and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bfla_pkg::ctrl_cmd_t             cmd,
  output bfla_pkg::dp_stat_t                   stat,
  input  wire logic                            req_kind,
  input  wire logic [bfla_pkg::BYTES_W-1:0]    req_bytes,
  input  wire logic [bfla_pkg::IDX_W-1:0]      req_block,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bfla_pkg::IDX_W-1:0]      out_block,
  output logic      [bfla_pkg::STAT_W-1:0]     out_status,
  output logic      [bfla_pkg::CNT_W-1:0]      out_used,
  output logic                                 out_last
);

  import bfla_pkg::*;

  // Captured request
  logic              kind;
  logic [NEED_W-1:0] need;
  logic [IDX_W-1:0]  rel_block;

  // Ring state
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] free_total;
  logic [CNT_W-1:0] used_total;
  logic [CNT_W-1:0] fill;       // entries below this index have been written
  logic [REM_W-1:0] remaining;

  // Read side
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_fresh;
  logic [IDX_W-1:0] granted;

  logic              ram_we;
  logic [BYTES_W:0]  bytes_sum;
  logic [NEED_W-1:0] need_calc;
  logic              need_zero;
  logic              too_large;
  logic              no_space;
  logic              push_ok;
  logic [CNT_W-1:0]  used_inc;
  logic [CNT_W-1:0]  used_dec;
  logic [STAT_W-1:0] single_status;

  // Round the byte count up to whole blocks
  assign bytes_sum = {1'b0, req_bytes} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign need_calc = NEED_W'(bytes_sum / BLOCK_BYTES);

  assign need_zero = (need == '0);
  assign too_large = (need > NEED_W'(MAX_BLOCKS_PER_REQUEST));
  assign no_space  = (free_total < CNT_W'(need));

  assign stat.grant_ok   = (kind == KIND_ALLOC) && !need_zero && !too_large && !no_space;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.last_grant = (remaining == REM_W'(1));

  assign push_ok  = (free_total < CNT_W'(TOTAL_BLOCKS));
  assign used_inc = (used_total < CNT_W'(TOTAL_BLOCKS)) ? used_total + 1'b1 : used_total;
  assign used_dec = (used_total != '0) ? used_total - 1'b1 : used_total;

  always_comb begin
    if (kind == KIND_RELEASE || need_zero) begin
      single_status = ST_DONE;
    end else if (too_large) begin
      single_status = ST_TOO_LARGE;
    end else begin
      single_status = ST_NO_SPACE;
    end
  end

  // Read the head for the first block, then read ahead one entry per pop
  assign ram_re    = cmd.issue_read || cmd.emit_grant;
  assign ram_raddr = cmd.emit_grant ? ring_next(head) : head;
  assign ram_we    = cmd.emit_single && (kind == KIND_RELEASE) && push_ok;

  // An entry never written reads as its own index, the ring's reset contents
  assign granted = rd_fresh ? ram_rdata : rd_addr;

  bfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TOTAL_BLOCKS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (rel_block),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind      <= req_kind;
      need      <= need_calc;
      rel_block <= req_block;
    end
    if (ram_re) begin
      rd_addr  <= ram_raddr;
      rd_fresh <= (CNT_W'(ram_raddr) < fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      free_total <= CNT_W'(TOTAL_BLOCKS);
      used_total <= '0;
      fill       <= '0;
      remaining  <= '0;
    end else begin
      if (cmd.issue_read) begin
        remaining <= need[REM_W-1:0];
      end
      if (cmd.emit_grant) begin
        head       <= ring_next(head);
        free_total <= free_total - 1'b1;
        used_total <= used_inc;
        remaining  <= remaining - 1'b1;
      end
      if (ram_we) begin
        tail       <= ring_next(tail);
        free_total <= free_total + 1'b1;
        used_total <= used_dec;
        if (fill != CNT_W'(TOTAL_BLOCKS)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_grant) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_grant) begin
      out_block  <= granted;
      out_status <= ST_GRANTED;
      out_used   <= used_inc;
      out_last   <= stat.last_grant;
    end else if (cmd.emit_single) begin
      out_block  <= '0;
      out_status <= single_status;
      out_used   <= ram_we ? used_dec : used_total;
      out_last   <= 1'b1;
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CNT_W'(TOTAL_BLOCKS))
    else $error("free count above ring size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_grant |-> (free_total != '0 && remaining != '0))
    else $error("pop from empty ring or past the request");

  a_mid_is_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_GRANTED))
    else $error("non-final result that is not a grant");

endmodule

`default_nettype wire

@@ rtl/block_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// block_free_list_allocator_top
// First-in first-out free list of disk block numbers with streaming ports.
// ----------------------------------------------------------------------------
// Each request on the slave side is either an allocate (tuser 0) carrying a
// byte count, or a release (tuser 1) carrying one block number. An allocate
// needs the byte count rounded up to whole 512-byte blocks; up to ten blocks
// are popped from the head of the free ring and returned one per result,
// with tlast on the final one. A zero byte count, a release, a request for
// more than ten blocks (too_large) or one that exceeds the free blocks
// (no_space) gives exactly one result with granted_block zero. After reset
// the ring holds blocks 0 to 1023 in order and is usable at once: a fill
// count stands in for the reset contents, so there is no clearing pass.
// Timing: one request is handled at a time. A granted allocate is
// accepted, then decided with the first ring read, then handed out one
// block per cycle from the ring memory's single read port while the master
// side takes results; a release or a refused allocate is accepted, decided
// and answered with one result. The next request is accepted while the
// final result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module block_free_list_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side: requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] byte_count, [25:16] block_number, rest 0
  input  wire logic        s_tuser,   // [0] kind
  // Master side: results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [9:0] granted_block, [20:10] blocks_in_use, rest 0
  output logic      [1:0]  m_tuser,   // [1:0] status
  output logic             m_tlast
);

  import bfla_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [IDX_W-1:0]  out_block;
  logic [CNT_W-1:0]  out_used;
  logic [STAT_W-1:0] out_status;

  // Sequence each request: accept, decide, emit
  bfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the ring, pointers and counters; drive the result register
  bfla_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_kind   (s_tuser),
    .req_bytes  (s_tdata[BYTES_W-1:0]),
    .req_block  (s_tdata[BYTES_W +: IDX_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_block  (out_block),
    .out_status (out_status),
    .out_used   (out_used),
    .out_last   (m_tlast)
  );

  // Pack the result fields, zero fill to whole bytes
  assign m_tdata = {3'b000, out_used, out_block};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
